// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication or sequence property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ----- design/fpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Flight phase detector package
// Payload types, configuration bundle, phase/event codes and reload table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

   localparam int ALT_FIELD_BITS = 17;
   localparam int LIMIT_BITS     = 8;
   localparam int PHASE_BITS     = 8;
   localparam int EVENT_BITS     = 3;
   localparam int RELOAD_BITS    = 15;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUND_ALTITUDE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAUNCH_RISE        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_APOGEE_LIMIT       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAIN_DEPLOY_ALT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAIN_LIMIT         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LANDING_CHANGE     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LANDING_LIMIT      = 3'd6;

   // Flight phases; any other value is idle
   localparam logic [PHASE_BITS-1:0] PHASE_PAD        = 8'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_PRE_APOGEE = 8'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_PRE_MAIN   = 8'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_PRE_LANDED = 8'd3;
   localparam logic [PHASE_BITS-1:0] PHASE_LANDED     = 8'd4;

   // Transition events
   localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_LAUNCHED = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_APOGEE   = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_MAIN     = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_LANDED   = 3'd4;

   // Telemetry timer reload values
   localparam logic [RELOAD_BITS-1:0] RELOAD_DEFAULT    = 15'd999;
   localparam logic [RELOAD_BITS-1:0] RELOAD_PRE_APOGEE = 15'd4999;
   localparam logic [RELOAD_BITS-1:0] RELOAD_PRE_MAIN   = 15'd1999;
   localparam logic [RELOAD_BITS-1:0] RELOAD_LANDED     = 15'd19999;

   localparam logic [LIMIT_BITS-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic                      mode;
      logic [ALT_FIELD_BITS-1:0] altitude;
   } req_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]  phase;
      logic [EVENT_BITS-1:0]  event_code;
      logic                   timer_update;
      logic [RELOAD_BITS-1:0] timer_reload;
   } rsp_type;

   typedef struct packed {
      logic [ALT_FIELD_BITS-1:0] ground_altitude;
      logic [ALT_FIELD_BITS-1:0] launch_rise_threshold;
      logic [LIMIT_BITS-1:0]     apogee_sample_limit;
      logic [ALT_FIELD_BITS-1:0] main_floor_altitude;
      logic [LIMIT_BITS-1:0]     main_sample_limit;
      logic [ALT_FIELD_BITS-1:0] landing_change_threshold;
      logic [LIMIT_BITS-1:0]     landing_sample_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ground_altitude:          17'd0,
      launch_rise_threshold:    17'd100,
      apogee_sample_limit:      8'd5,
      main_floor_altitude:      17'd1500,
      main_sample_limit:        8'd5,
      landing_change_threshold: 17'd5,
      landing_sample_limit:     8'd10
   };

   function automatic logic [RELOAD_BITS-1:0] reload_for(input logic [PHASE_BITS-1:0] ph);
      logic [RELOAD_BITS-1:0] r;
      unique case (ph)
         PHASE_PRE_APOGEE: r = RELOAD_PRE_APOGEE;
         PHASE_PRE_MAIN:   r = RELOAD_PRE_MAIN;
         PHASE_LANDED:     r = RELOAD_LANDED;
         default:          r = RELOAD_DEFAULT;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/fpd_csr.sv -----
// ----------------------------------------------------------------------------
// Flight phase detector configuration registers
// Holds the seven thresholds and limits written through the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_csr
   import fpd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GROUND_ALTITUDE: cfg_in.ground_altitude          = csr_wdata;
            CSR_LAUNCH_RISE:     cfg_in.launch_rise_threshold    = csr_wdata;
            CSR_APOGEE_LIMIT:    cfg_in.apogee_sample_limit      = csr_wdata[LIMIT_BITS-1:0];
            CSR_MAIN_DEPLOY_ALT: cfg_in.main_floor_altitude      = csr_wdata;
            CSR_MAIN_LIMIT:      cfg_in.main_sample_limit        = csr_wdata[LIMIT_BITS-1:0];
            CSR_LANDING_CHANGE:  cfg_in.landing_change_threshold = csr_wdata;
            CSR_LANDING_LIMIT:   cfg_in.landing_sample_limit     = csr_wdata[LIMIT_BITS-1:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/fpd_tracker.sv -----
// ----------------------------------------------------------------------------
// Flight phase tracker
// Phase, peak, previous altitude and sample counter with next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_tracker
   import fpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   localparam int AW = ALT_FIELD_BITS;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [AW-1:0]         peak_ff, peak_in;
   logic [AW-1:0]         prev_ff, prev_in;
   logic [LIMIT_BITS-1:0] count_ff, count_in;

   logic [AW-1:0]         alt;
   logic [AW-1:0]         ground;
   logic [AW-1:0]         rise;
   logic [AW-1:0]         main_alt;
   logic [AW-1:0]         still_thr;
   logic [AW:0]           launch_level;
   logic [AW-1:0]         diff;
   logic [LIMIT_BITS-1:0] count_inc;
   logic [EVENT_BITS-1:0] event_code;
   logic                  timer_update;

   assign alt       = AW'(req.altitude);
   assign ground    = AW'(cfg.ground_altitude);
   assign rise      = AW'(cfg.launch_rise_threshold);
   assign main_alt  = AW'(cfg.main_floor_altitude);
   assign still_thr = AW'(cfg.landing_change_threshold);

   assign launch_level = {1'b0, ground} + {1'b0, rise};
   assign diff         = (alt >= prev_ff) ? (alt - prev_ff) : (prev_ff - alt);
   // saturate at the top
   assign count_inc    = (count_ff == COUNT_MAX) ? count_ff : (count_ff + 1'b1);

   always_comb begin
      phase_in     = phase_ff;
      peak_in      = peak_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      event_code   = EV_NONE;
      timer_update = 1'b0;
      if (req.mode) begin
         phase_in     = phase_ff + 1'b1;
         timer_update = 1'b1;
      end else begin
         unique case (phase_ff)
            PHASE_PAD: begin
               if ({1'b0, alt} > launch_level) begin
                  phase_in     = PHASE_PRE_APOGEE;
                  event_code   = EV_LAUNCHED;
                  timer_update = 1'b1;
               end
            end
            PHASE_PRE_APOGEE: begin
               if (alt > peak_ff) begin
                  peak_in  = alt;
                  count_in = '0;
               end else if (count_inc > cfg.apogee_sample_limit) begin
                  phase_in     = PHASE_PRE_MAIN;
                  count_in     = '0;
                  event_code   = EV_APOGEE;
                  timer_update = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
            PHASE_PRE_MAIN: begin
               if (alt < main_alt) begin
                  if (count_inc > cfg.main_sample_limit) begin
                     phase_in     = PHASE_PRE_LANDED;
                     prev_in      = alt;
                     count_in     = '0;
                     event_code   = EV_MAIN;
                     timer_update = 1'b1;
                  end else begin
                     count_in = count_inc;
                  end
               end else begin
                  count_in = '0;
               end
            end
            PHASE_PRE_LANDED: begin
               prev_in = alt;
               if (diff < still_thr) begin
                  if (count_inc > cfg.landing_sample_limit) begin
                     phase_in     = PHASE_LANDED;
                     count_in     = '0;
                     event_code   = EV_LANDED;
                     timer_update = 1'b1;
                  end else begin
                     count_in = count_inc;
                  end
               end else begin
                  count_in = '0;
               end
            end
            PHASE_LANDED: begin
               timer_update = 1'b1;
            end
            default: ;  // idle phase: hold everything
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_PAD;
         peak_ff  <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         peak_ff  <= peak_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

   assign result = '{
      phase:        phase_in,
      event_code:   event_code,
      timer_update: timer_update,
      timer_reload: reload_for(phase_in)
   };

endmodule

`default_nettype wire

// ----- design/flight_phase_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Flight phase detector
// Tracks pad, pre-apogee, pre-main, pre-landed and landed from altitude
// samples and button events; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data): each request is an
//   altitude sample (mode 0) or a button press (mode 1) advancing the phase.
//   Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response
//   per request, in order, with phase, event code and telemetry timer reload.
//   CSR port (csr_write / csr_index / csr_wdata): single-cycle register
//   writes; write only while no request is in flight.
//   A request passes the input register, then the response register.
//   Throughput: one request per cycle while rsp_stall is low; the tracker
//   state updates as a request moves on, so the next request sees it directly.
//   Stall: a stalled response holds in the response register while one more
//   request waits in the input register; req_stall is high while both hold a
//   request and rsp_stall is high. Reset (synchronous) empties both stages,
//   puts the phase on the pad and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module flight_phase_detector_unit
   import fpd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_type                   req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;

   logic    rsp_free;
   logic    in_advance;
   logic    req_accept;

   fpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the tracker state only as its request moves to the response stage.
   fpd_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Response register is free when empty or being taken this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign in_advance = in_valid_ff && rsp_free;
   assign req_stall  = in_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !in_advance);
   assign rsp_valid_in = in_advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: input loads on accept, response on advance; hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (in_advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted request always lands in the input stage.
   `ASSERT_PROP(a_accept_fills, clock, reset, req_accept |=> in_valid_ff)
   // A request leaving the input stage always produces a response.
   `ASSERT_PROP(a_advance_responds, clock, reset, in_advance |=> rsp_valid_ff)
   // Every transition event reloads the telemetry timer.
   `ASSERT_NEVER(a_event_updates, clock, reset,
      rsp_valid_ff && (rsp_data_ff.event_code != EV_NONE) && !rsp_data_ff.timer_update)
   // Launch always lands in pre-apogee.
   `ASSERT_NEVER(a_launch_phase, clock, reset,
      rsp_valid_ff && (rsp_data_ff.event_code == EV_LAUNCHED)
      && (rsp_data_ff.phase != PHASE_PRE_APOGEE))

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Flight phase detector testbench
// Drives altitude samples and button presses through the request channel,
// predicts each response from an in-bench flight model and compares every
// field in order. Directed flights cover the register defaults, zero and full
// scale limits, the phase wrap, the unwrapped launch compare and counter
// saturation. Shaped random flights then run under many register settings
// with random request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module testbench
   import fpd_pkg::*;
();

   localparam int ALT_MAX           = (1 << ALT_FIELD_BITS) - 1;
   localparam int CYCLE_LIMIT       = 1_000_000;
   localparam int SETTLE_CYCLES     = 8;
   localparam int SETTING_COUNT     = 12;
   localparam int ITEMS_PER_SETTING = 55;
   localparam int SATURATE_RUN      = 258;
   localparam int PRINT_LIMIT       = 40;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Flight model: register copy and tracked flight state
   cfg_type                   settings;
   logic [PHASE_BITS-1:0]     cur_phase;
   logic [ALT_FIELD_BITS-1:0] top_altitude;
   logic [ALT_FIELD_BITS-1:0] last_altitude;
   logic [LIMIT_BITS-1:0]     run_count;

   // Responses predicted for accepted requests, oldest first
   rsp_type                   predicted_responses[$];
   rsp_type                   oldest_response;

   logic                      idling_on      = 1'b0;
   int                        mismatch_count = 0;
   int                        response_count = 0;
   int unsigned               cycle_count    = 0;

   flight_phase_detector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop: a hung handshake or a missing response ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Flight model
   // ------------------------------------------------------------------------

   // Saturate at full scale so a limit of 255 is never passed.
   function automatic void bump_count();
      if (run_count != COUNT_MAX)
         run_count = run_count + 1'b1;
   endfunction

   // Advance the model by one request and return the response it should give.
   function automatic rsp_type predict_flight_step(input req_type r);
      rsp_type                   o;
      logic [ALT_FIELD_BITS:0]   launch_level;
      logic [ALT_FIELD_BITS-1:0] change;
      o = '0;
      o.event_code = EV_NONE;
      if (r.mode) begin
         // Button: step the phase, wrap past 255, leave everything else.
         cur_phase = cur_phase + 1'b1;
         o.timer_update = 1'b1;
      end else begin
         case (cur_phase)
            PHASE_PAD: begin
               // Compare one bit wider so ground plus rise cannot wrap.
               launch_level = {1'b0, settings.ground_altitude}
                            + {1'b0, settings.launch_rise_threshold};
               if ({1'b0, r.altitude} > launch_level) begin
                  cur_phase      = PHASE_PRE_APOGEE;
                  o.event_code   = EV_LAUNCHED;
                  o.timer_update = 1'b1;
               end
            end
            PHASE_PRE_APOGEE: begin
               if (r.altitude > top_altitude) begin
                  top_altitude = r.altitude;
                  run_count    = '0;
               end else begin
                  bump_count();
                  if (run_count > settings.apogee_sample_limit) begin
                     cur_phase      = PHASE_PRE_MAIN;
                     run_count      = '0;
                     o.event_code   = EV_APOGEE;
                     o.timer_update = 1'b1;
                  end
               end
            end
            PHASE_PRE_MAIN: begin
               if (r.altitude < settings.main_floor_altitude) begin
                  bump_count();
                  if (run_count > settings.main_sample_limit) begin
                     cur_phase      = PHASE_PRE_LANDED;
                     last_altitude  = r.altitude;
                     run_count      = '0;
                     o.event_code   = EV_MAIN;
                     o.timer_update = 1'b1;
                  end
               end else begin
                  run_count = '0;
               end
            end
            PHASE_PRE_LANDED: begin
               change = (r.altitude >= last_altitude) ? r.altitude - last_altitude
                                                      : last_altitude - r.altitude;
               if (change < settings.landing_change_threshold) begin
                  bump_count();
                  if (run_count > settings.landing_sample_limit) begin
                     cur_phase      = PHASE_LANDED;
                     run_count      = '0;
                     o.event_code   = EV_LANDED;
                     o.timer_update = 1'b1;
                  end
               end else begin
                  run_count = '0;
               end
               last_altitude = r.altitude;
            end
            PHASE_LANDED: begin
               o.timer_update = 1'b1;
            end
            default: begin
               // Idle phases ignore samples.
            end
         endcase
      end
      o.phase = cur_phase;
      case (cur_phase)
         PHASE_PRE_APOGEE: o.timer_reload = RELOAD_PRE_APOGEE;
         PHASE_PRE_MAIN:   o.timer_reload = RELOAD_PRE_MAIN;
         PHASE_LANDED:     o.timer_reload = RELOAD_LANDED;
         default:          o.timer_reload = RELOAD_DEFAULT;
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!idling_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clip(input int x);
      return (x > ALT_MAX) ? ALT_MAX : ((x < 0) ? 0 : x);
   endfunction

   // Fill the unused upper bits of a limit write with noise; only the
   // low byte may land in the register.
   function automatic logic [CSR_DATA_BITS-1:0] limit_word(input logic [LIMIT_BITS-1:0] v);
      logic [CSR_DATA_BITS-1:0] w;
      w = CSR_DATA_BITS'($urandom);
      w[LIMIT_BITS-1:0] = v;
      return w;
   endfunction

   // Hold a request until the block takes it, then record its prediction.
   // Valid stays high into the next request when no gap is drawn, so it is
   // never lowered and raised in the same step.
   task automatic send_request(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_valid)
            req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted_responses.push_back(predict_flight_step(item));
   endtask

   task automatic send_sample(input int alt);
      req_type item;
      item.mode     = 1'b0;
      item.altitude = ALT_FIELD_BITS'(alt);
      send_request(item);
   endtask

   // Button presses carry a random altitude that the block must ignore.
   task automatic send_button();
      req_type item;
      item.mode     = 1'b1;
      item.altitude = ALT_FIELD_BITS'($urandom_range(0, ALT_MAX));
      send_request(item);
   endtask

   // Drop valid and wait until every predicted response has been checked.
   task automatic drain_responses();
      if (req_valid)
         req_valid <= 1'b0;
      while (predicted_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic put_register(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [CSR_DATA_BITS-1:0]  word);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= word;
      @(posedge clock);
   endtask

   // Write all seven registers back to back; call only while drained.
   task automatic write_settings(input cfg_type c);
      put_register(CSR_GROUND_ALTITUDE, c.ground_altitude);
      put_register(CSR_LAUNCH_RISE,     c.launch_rise_threshold);
      put_register(CSR_APOGEE_LIMIT,    limit_word(c.apogee_sample_limit));
      put_register(CSR_MAIN_DEPLOY_ALT, c.main_floor_altitude);
      put_register(CSR_MAIN_LIMIT,      limit_word(c.main_sample_limit));
      put_register(CSR_LANDING_CHANGE,  c.landing_change_threshold);
      put_register(CSR_LANDING_LIMIT,   limit_word(c.landing_sample_limit));
      csr_write <= 1'b0;
      settings = c;
   endtask

   // Setting 0 is all zero, setting 1 full scale, the rest short flights
   // with an occasional extreme value mixed in.
   function automatic cfg_type random_settings(input int kind);
      cfg_type c;
      if (kind == 0) begin
         c = '0;
      end else if (kind == 1) begin
         c.ground_altitude          = ALT_FIELD_BITS'(ALT_MAX);
         c.launch_rise_threshold    = ALT_FIELD_BITS'(ALT_MAX);
         c.apogee_sample_limit      = COUNT_MAX;
         c.main_floor_altitude      = ALT_FIELD_BITS'(ALT_MAX);
         c.main_sample_limit        = COUNT_MAX;
         c.landing_change_threshold = ALT_FIELD_BITS'(ALT_MAX);
         c.landing_sample_limit     = COUNT_MAX;
      end else begin
         c.ground_altitude = ALT_FIELD_BITS'(($urandom_range(0, 3) != 0)
                                             ? $urandom_range(0, 4000)
                                             : $urandom_range(0, ALT_MAX));
         c.launch_rise_threshold = ALT_FIELD_BITS'(($urandom_range(0, 4) == 0)
                                                   ? 0 : $urandom_range(1, 1500));
         c.apogee_sample_limit = LIMIT_BITS'(($urandom_range(0, 9) == 0)
                                             ? 255 : $urandom_range(0, 6));
         c.main_floor_altitude = ALT_FIELD_BITS'(($urandom_range(0, 5) == 0)
                                                 ? $urandom_range(0, ALT_MAX)
                                                 : $urandom_range(500, 8000));
         c.main_sample_limit = LIMIT_BITS'(($urandom_range(0, 9) == 0)
                                           ? 255 : $urandom_range(0, 6));
         if ($urandom_range(0, 7) == 0)
            c.landing_change_threshold = ALT_FIELD_BITS'($urandom_range(0, 1) ? ALT_MAX : 0);
         else
            c.landing_change_threshold = ALT_FIELD_BITS'($urandom_range(1, 30));
         c.landing_sample_limit = LIMIT_BITS'(($urandom_range(0, 9) == 0)
                                              ? 255 : $urandom_range(0, 8));
      end
      return c;
   endfunction

   // Pick the next request from the tracked phase so that most samples push
   // the flight forward; keep a share of button presses and wild samples.
   function automatic req_type shape_request();
      req_type r;
      int      level;
      int      spread;
      r.mode     = 1'b0;
      r.altitude = ALT_FIELD_BITS'($urandom_range(0, ALT_MAX));
      if (cur_phase > PHASE_PRE_LANDED) begin
         // Landed or idle: mostly press on toward the wrap back to the pad.
         r.mode = ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 39) == 0) begin
         r.mode = 1'b1;
      end else if ($urandom_range(0, 19) != 0) begin
         case (cur_phase)
            PHASE_PAD: begin
               level = int'(settings.ground_altitude) + int'(settings.launch_rise_threshold);
               if (level < ALT_MAX) begin
                  if ($urandom_range(0, 2) == 0)
                     r.altitude = ALT_FIELD_BITS'(clip(level + 1 + $urandom_range(0, 2000)));
                  else
                     r.altitude = ALT_FIELD_BITS'($urandom_range(level > 2000 ? level - 2000 : 0,
                                                                 level));
               end
            end
            PHASE_PRE_APOGEE: begin
               level = int'(top_altitude);
               if (level < ALT_MAX && $urandom_range(0, 2) == 0)
                  r.altitude = ALT_FIELD_BITS'(clip(level + 1 + $urandom_range(0, 800)));
               else
                  r.altitude = ALT_FIELD_BITS'(level
                                               - $urandom_range(0, level < 800 ? level : 800));
            end
            PHASE_PRE_MAIN: begin
               level = int'(settings.main_floor_altitude);
               if (level > 0 && $urandom_range(0, 4) != 0)
                  r.altitude = ALT_FIELD_BITS'($urandom_range(level > 3000 ? level - 3000 : 0,
                                                              level - 1));
               else
                  r.altitude = ALT_FIELD_BITS'(clip(level + $urandom_range(0, 3000)));
            end
            default: begin
               spread = int'(settings.landing_change_threshold);
               if (spread > 0 && $urandom_range(0, 5) != 0) begin
                  spread = $urandom_range(0, spread - 1);
                  if ($urandom_range(0, 1) != 0)
                     r.altitude = ALT_FIELD_BITS'(clip(int'(last_altitude) + spread));
                  else
                     r.altitude = ALT_FIELD_BITS'(clip(int'(last_altitude) - spread));
               end
            end
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("response %0d: %s got %0d want %0d", response_count, what, got, want);
      mismatch_count++;
   endtask

   // Back-pressure: stall for random stretches while idling is on.
   initial begin : stall_driver
      int hold;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 2) == 0) begin
            hold = pick_gap() + 1;
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_responses.size() == 0) begin
            report_mismatch("response with none pending, phase", 32'(rsp_data.phase), '0);
         end else begin
            oldest_response = predicted_responses.pop_front();
            if (rsp_data.phase !== oldest_response.phase)
               report_mismatch("phase", 32'(rsp_data.phase), 32'(oldest_response.phase));
            if (rsp_data.event_code !== oldest_response.event_code)
               report_mismatch("event_code", 32'(rsp_data.event_code),
                               32'(oldest_response.event_code));
            if (rsp_data.timer_update !== oldest_response.timer_update)
               report_mismatch("timer_update", 32'(rsp_data.timer_update),
                               32'(oldest_response.timer_update));
            if (rsp_data.timer_reload !== oldest_response.timer_reload)
               report_mismatch("timer_reload", 32'(rsp_data.timer_reload),
                               32'(oldest_response.timer_reload));
         end
         response_count++;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset values: no launch at exactly ground plus rise, launch one foot
   // above, a rising sample restarts the count, a sample equal to the peak
   // counts, apogee on the sixth non-rising sample.
   task automatic test_default_flight();
      send_sample(0);
      send_sample(100);
      send_sample(101);
      send_sample(5000);
      send_sample(5000);
      repeat (5) send_sample(4999);
   endtask

   // Zero limits fire on the first counted sample; a full scale still
   // threshold counts everything but the full scale jump. Then step through
   // landed into the idle phases.
   task automatic test_limit_extremes();
      cfg_type c;
      drain_responses();
      c = CFG_RESET;
      c.main_floor_altitude      = 1;
      c.main_sample_limit        = '0;
      c.landing_change_threshold = ALT_FIELD_BITS'(ALT_MAX);
      c.landing_sample_limit     = '0;
      write_settings(c);
      send_sample(1);
      send_sample(0);
      send_sample(ALT_MAX);
      send_sample(ALT_MAX - 1);
      send_sample(ALT_MAX);
      send_button();
      send_sample(0);
      send_button();
   endtask

   // Press through the idle phases until the phase wraps to the pad, then
   // check that ground plus rise is compared without wrapping.
   task automatic test_phase_wrap();
      cfg_type c;
      while (cur_phase != PHASE_PAD) begin
         if ($urandom_range(0, 7) == 0)
            send_sample($urandom_range(0, ALT_MAX));
         else
            send_button();
      end
      drain_responses();
      c = settings;
      c.ground_altitude       = ALT_FIELD_BITS'(ALT_MAX);
      c.launch_rise_threshold = ALT_FIELD_BITS'(ALT_MAX);
      write_settings(c);
      send_sample(ALT_MAX);
      drain_responses();
      c.launch_rise_threshold = '0;
      write_settings(c);
      send_sample(ALT_MAX);
      drain_responses();
      c.ground_altitude = ALT_FIELD_BITS'(ALT_MAX - 1);
      write_settings(c);
      send_sample(ALT_MAX);
   endtask

   // Limits of 255 with every sample counted: the count saturates and no
   // transition fires; buttons carry the saturated count into the next phase.
   task automatic test_counter_saturation();
      cfg_type c;
      drain_responses();
      c = settings;
      c.apogee_sample_limit      = COUNT_MAX;
      c.main_floor_altitude      = ALT_FIELD_BITS'(ALT_MAX);
      c.main_sample_limit        = COUNT_MAX;
      c.landing_change_threshold = ALT_FIELD_BITS'(ALT_MAX);
      c.landing_sample_limit     = COUNT_MAX;
      write_settings(c);
      repeat (SATURATE_RUN) send_sample($urandom_range(0, top_altitude));
      send_button();
      repeat (SATURATE_RUN) send_sample($urandom_range(0, ALT_MAX - 1));
      send_button();
      repeat (SATURATE_RUN) send_sample($urandom_range(1, ALT_MAX - 1));
      send_button();
   endtask

   // Shaped random flights under a new register setting per round; every
   // fourth round runs without idling on either side.
   task automatic test_random_flights();
      req_type item;
      int      counted;
      for (int round = 0; round < SETTING_COUNT; round++) begin
         drain_responses();
         write_settings(random_settings(round));
         idling_on = (round % 4 != 3);
         counted   = 0;
         while (counted < ITEMS_PER_SETTING) begin
            item = shape_request();
            // Samples in an idle phase do nothing; leave them out of the count.
            if (item.mode || cur_phase <= PHASE_LANDED)
               counted++;
            send_request(item);
         end
      end
   endtask

   initial begin
      settings      = CFG_RESET;
      cur_phase     = PHASE_PAD;
      top_altitude  = '0;
      last_altitude = '0;
      run_count     = '0;
      repeat (12) @(posedge clock);
      reset     <= 1'b0;
      idling_on = 1'b1;

      test_default_flight();
      test_limit_extremes();
      test_phase_wrap();
      test_counter_saturation();
      test_random_flights();

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
